// ===== sv/gww_pkg.sv =====
// Shared types and constants of the greedy word wrap unit.
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

  // Default word buffer depth, the largest word piece held at once.
  localparam int WordMaxDef = 56;
  // Word lengths never exceed 56, so six bits always hold them.
  localparam int LenW = 6;
  // Depths of the command queue and of the result queue.
  localparam int CmdDepth = 2;
  localparam int OutDepth = 4;

  localparam logic [7:0] ChSpace        = 8'd32;
  localparam logic [7:0] ChNewline      = 8'd10;
  localparam logic [7:0] LineWidthReset = 8'd80;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_SPACE,
    SEP_NEWLINE
  } sep_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_word_t;

  // One placement job handed from the front to the back.
  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] len;
    sep_e            sep;
    logic            close;
    logic            last;
  } cmd_t;

  // The back returns a buffer bank once its last character has been read.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

`default_nettype wire

// ===== sv/gww_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gww_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/gww_fifo.sv =====
// Small register based first-in first-out queue.
`timescale 1ns / 1ps
`default_nettype none

module gww_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [Width-1:0]           rdata_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gww_front.sv =====
// Front end: takes input words, buffers word characters and decides placement.
`timescale 1ns / 1ps
`default_nettype none

module gww_front
  import gww_pkg::*;
#(
  parameter int WORD_MAX = WordMaxDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  in_word_t                        in_word_i,
  input  logic [7:0]                      line_width_i,
  output logic                            ram_we_o,
  output logic [$clog2(WORD_MAX):0]       ram_waddr_o,
  output logic [7:0]                      ram_wdata_o,
  output logic                            cmd_push_o,
  output cmd_t                            cmd_o,
  input  logic                            cmd_full_i,
  input  rel_t                            rel_i
);

  localparam int IdxW = $clog2(WORD_MAX);
  localparam logic [7:0] WordMaxB = 8'(WORD_MAX);

  logic [LenW-1:0] wlen_q, wlen_d;
  logic [7:0]      line_q, line_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;
  logic            pend_q, pend_d;

  logic [7:0]      eff_w, limit, wlen8;
  logic            ovf, accept, is_sp;
  logic [9:0]      fit_sum;
  logic [LenW-1:0] plen;
  logic            pclose, plast, do_push;
  sep_e            psep;

  assign eff_w  = (line_width_i == 8'd0) ? 8'd1 : line_width_i;
  assign limit  = (eff_w < WordMaxB) ? eff_w : WordMaxB;
  assign wlen8  = {{(8 - LenW){1'b0}}, wlen_q};
  assign ovf    = (wlen8 >= limit);
  assign is_sp  = (in_word_i.in_byte == ChSpace);
  // The stall does not look at the payload: the bank a character may go to must be free.
  assign full   = pend_q || cmd_full_i || busy_q[bank_q] || (ovf && busy_q[~bank_q]);
  assign accept = push && !full;

  always_comb begin
    wlen_d  = wlen_q;
    line_d  = line_q;
    bank_d  = bank_q;
    busy_d  = busy_q;
    pend_d  = pend_q;
    plen    = '0;
    pclose  = 1'b0;
    plast   = 1'b0;
    do_push = 1'b0;
    psep    = SEP_NONE;
    fit_sum = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = {bank_q, wlen_q[IdxW-1:0]};
    ram_wdata_o = in_word_i.in_byte;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (pend_q) begin
      // Second placement of an overflowing last character: one-character piece plus close.
      if (!cmd_full_i) begin
        do_push = 1'b1;
        plen    = LenW'(1);
        pclose  = 1'b1;
        plast   = 1'b1;
        pend_d  = 1'b0;
      end
    end else if (accept) begin
      if (is_sp) begin
        plen    = wlen_q;
        pclose  = in_word_i.text_end;
        plast   = 1'b1;
        do_push = (wlen_q != '0) || in_word_i.text_end;
      end else if (ovf) begin
        plen        = wlen_q;
        plast       = !in_word_i.text_end;
        do_push     = 1'b1;
        ram_we_o    = 1'b1;
        ram_waddr_o = {~bank_q, {IdxW{1'b0}}};
        pend_d      = in_word_i.text_end;
      end else begin
        ram_we_o = 1'b1;
        wlen_d   = wlen_q + LenW'(1);
        if (in_word_i.text_end) begin
          plen    = wlen_q + LenW'(1);
          pclose  = 1'b1;
          plast   = 1'b1;
          do_push = 1'b1;
        end
      end
    end

    if (do_push) begin
      fit_sum = {2'b00, line_q} + 10'd1 + {{(10 - LenW){1'b0}}, plen};
      if (plen != '0) begin
        if (line_q == 8'd0) begin
          psep   = SEP_NONE;
          line_d = {{(8 - LenW){1'b0}}, plen};
        end else if (fit_sum <= {2'b00, eff_w}) begin
          psep   = SEP_SPACE;
          line_d = fit_sum[7:0];
        end else begin
          psep   = SEP_NEWLINE;
          line_d = {{(8 - LenW){1'b0}}, plen};
        end
        busy_d[bank_q] = 1'b1;
        bank_d         = ~bank_q;
        wlen_d         = '0;
      end
      if (pclose) begin
        line_d = 8'd0;
        wlen_d = '0;
      end
    end

    // An overflowing character starts the next piece in the other bank.
    if (!pend_q && accept && !is_sp && ovf) begin
      wlen_d = LenW'(1);
    end

    cmd_push_o  = do_push;
    cmd_o.bank  = bank_q;
    cmd_o.len   = plen;
    cmd_o.sep   = psep;
    cmd_o.close = pclose;
    cmd_o.last  = plast;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
      line_q <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
      pend_q <= 1'b0;
    end else begin
      wlen_q <= wlen_d;
      line_q <= line_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gww_back.sv =====
// Back end: replays placement jobs as a stream of output characters.
`timescale 1ns / 1ps
`default_nettype none

module gww_back
  import gww_pkg::*;
#(
  parameter int WORD_MAX = WordMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  cmd_t                          cmd_i,
  output logic                          cmd_pop_o,
  output logic                          ram_re_o,
  output logic [$clog2(WORD_MAX):0]     ram_raddr_o,
  input  logic [7:0]                    ram_rdata_i,
  input  logic [$clog2(OutDepth+1)-1:0] out_count_i,
  output logic                          out_push_o,
  output out_word_t                     out_word_o,
  output rel_t                          rel_o
);

  localparam int IdxW = $clog2(WORD_MAX);
  localparam int CntW = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEP,
    ST_DATA,
    ST_CLOSE
  } state_e;

  state_e          state_q;
  cmd_t            cur_q;
  logic [IdxW-1:0] idx_q;
  logic            slot_v_q, slot_mem_q, slot_last_q, slot_done_q;
  logic [7:0]      slot_byte_q;
  rel_t            rel_q;
  logic            can_issue, final_ch;

  // One slot may be in flight, so the queue must have room for it as well.
  assign can_issue   = (out_count_i + CntW'(slot_v_q)) < CntW'(OutDepth);
  assign final_ch    = ((LenW'(idx_q) + LenW'(1)) == cur_q.len);
  assign cmd_pop_o   = (state_q == ST_IDLE) && !cmd_empty_i;
  assign ram_re_o    = (state_q == ST_DATA) && can_issue;
  assign ram_raddr_o = {cur_q.bank, idx_q};
  assign rel_o       = rel_q;

  assign out_push_o           = slot_v_q;
  assign out_word_o.out_byte  = slot_mem_q ? ram_rdata_i : slot_byte_q;
  assign out_word_o.run_last  = slot_last_q;
  assign out_word_o.text_done = slot_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      idx_q       <= '0;
      slot_v_q    <= 1'b0;
      slot_mem_q  <= 1'b0;
      slot_last_q <= 1'b0;
      slot_done_q <= 1'b0;
      slot_byte_q <= '0;
      rel_q       <= '0;
    end else begin
      slot_v_q    <= 1'b0;
      rel_q.valid <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            cur_q <= cmd_i;
            idx_q <= '0;
            if (cmd_i.sep != SEP_NONE) begin
              state_q <= ST_SEP;
            end else if (cmd_i.len != '0) begin
              state_q <= ST_DATA;
            end else begin
              state_q <= ST_CLOSE;
            end
          end
        end
        ST_SEP: begin
          if (can_issue) begin
            slot_v_q    <= 1'b1;
            slot_mem_q  <= 1'b0;
            slot_byte_q <= (cur_q.sep == SEP_SPACE) ? ChSpace : ChNewline;
            slot_last_q <= 1'b0;
            slot_done_q <= 1'b0;
            state_q     <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (can_issue) begin
            slot_v_q    <= 1'b1;
            slot_mem_q  <= 1'b1;
            slot_last_q <= cur_q.last && final_ch && !cur_q.close;
            slot_done_q <= 1'b0;
            idx_q       <= idx_q + IdxW'(1);
            if (final_ch) begin
              rel_q.valid <= 1'b1;
              rel_q.bank  <= cur_q.bank;
              state_q     <= cur_q.close ? ST_CLOSE : ST_IDLE;
            end
          end
        end
        ST_CLOSE: begin
          if (can_issue) begin
            slot_v_q    <= 1'b1;
            slot_mem_q  <= 1'b0;
            slot_byte_q <= ChNewline;
            slot_last_q <= cur_q.last;
            slot_done_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/greedy_word_wrap_unit.sv =====
// Top level of the greedy word wrap unit.
`timescale 1ns / 1ps
`default_nettype none

// Greedy word wrap unit. Text enters one byte per input word through a queue style
// port (push/full) and leaves wrapped to line_width characters per line through a
// second queue style port (empty/pop). Spaces separate words and runs of them
// collapse; each word is held in a two-bank buffer and, once its separator or the
// end of the text arrives, is placed after one space if it fits on the current line,
// or after a line break if not. A word longer than the buffer or the width is cut
// into pieces. The input word marked text_end flushes the pending word and closes
// the text with a line break carrying text_done. The front end takes one input word
// per cycle while a buffer bank is free and the command queue has room; a character
// that overflows the buffer on the last byte of the text holds the front while it
// places a second, one-character piece. The back end sends one output character per
// cycle while the result queue has room, and takes each placed word from the command
// queue while idle. The front stalls when the next character would land in a bank
// whose previous word is still being replayed. The width register is written
// through its own valid/ready port, which is always ready, and should only be
// changed while the unit is idle; a width of zero acts as one.
module greedy_word_wrap_unit
  import gww_pkg::*;
#(
  parameter int WORD_MAX = WordMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_word_t   in_word_i,
  output logic       empty,
  input  logic       pop,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  // Each bank spans a power-of-two range so the bank bit is simply the top address bit.
  localparam int AddrW    = $clog2(WORD_MAX) + 1;
  localparam int RamDepth = 2 ** AddrW;
  localparam int CmdW     = $bits(cmd_t);
  localparam int OutW     = $bits(out_word_t);

  logic [7:0] line_width_q;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;
  rel_t rel;

  logic                          out_push, out_full;
  out_word_t                     out_in;
  logic [$clog2(OutDepth+1)-1:0] out_count;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_width_q <= cfg_data_i;
    end
  end

  gww_front #(
    .WORD_MAX(WORD_MAX)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_word_i,
    .line_width_i(line_width_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full),
    .rel_i       (rel)
  );

  gww_ram #(
    .Width(8),
    .Depth(RamDepth)
  ) u_word_ram (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Placement jobs wait here, so the front and the back stall independently.
  gww_fifo #(
    .Width(CmdW),
    .Depth(CmdDepth)
  ) u_cmd_fifo (
    .clk_i,
    .rst_ni,
    .push_i (cmd_push),
    .full_o (cmd_full),
    .wdata_i(cmd_in),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(cmd_out),
    .count_o()
  );

  gww_back #(
    .WORD_MAX(WORD_MAX)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .out_count_i(out_count),
    .out_push_o (out_push),
    .out_word_o (out_in),
    .rel_o      (rel)
  );

  // Result queue: a waiting result never holds up the back end while there is room.
  gww_fifo #(
    .Width(OutW),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i (out_push),
    .full_o (out_full),
    .wdata_i(out_in),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(out_word_o),
    .count_o(out_count)
  );

  // The back end reserves room before it issues, so the result queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(out_push && out_full))
    else $error("result queue written while full");

  // The front checks for room before it hands over a job.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_push && cmd_full))
    else $error("command queue written while full");

  // A job either carries characters or closes the text; an empty job would emit nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_push |-> (cmd_in.len != '0 || cmd_in.close))
    else $error("empty placement job");

  // The closing line break is always the last character of its input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && out_word_o.text_done) |-> (out_word_o.run_last &&
                                             out_word_o.out_byte == ChNewline))
    else $error("text close is not a final line break");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for greedy_word_wrap_unit: directed text, then random text.
`timescale 1ns / 1ps

module tb_top;
  import gww_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The longest
  // correct quiet stretch is the receiver hold-off below plus a settle pause.
  localparam int StallLimit = 3000;
  // Cycles the receiver refuses results while the sender keeps pushing.
  localparam int RxHoldCycles = 400;
  // Cycles allowed for the unit to finish internal work that yields no result.
  localparam int SettleCycles = 64;
  // Random text bytes per phase; the generated sentences are cut to this length.
  localparam int RandomPerPhase = 33;
  localparam int NumPhases = 6;
  localparam int MaxPrinted = 40;

  localparam out_word_t NoWord = '0;

  // Directed rows either write the width register or send one text byte.
  typedef enum logic {
    ROW_CHAR,
    ROW_WIDTH
  } row_kind_e;

  // A typed row carries its expected outcome: no result, or one result in "first".
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;
    logic       text_end;
    logic       typed;
    logic       one_result;
    out_word_t  first;
  } row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_word_t  in_word;
  logic      empty;
  logic      pop;
  out_word_t out_word;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  // Copy of the unit's state as the predictor sees it.
  logic [7:0]  width_q;
  logic [7:0]  word_buf [WordMaxDef];
  int unsigned word_len;
  int unsigned line_len;

  out_word_t step_q[$];     // characters produced by the byte now being predicted
  out_word_t wrapped_q[$];  // wrapped characters still owed by the unit
  in_word_t  text_q[$];     // random text of the current phase
  row_t      plan_q[$];     // directed rows

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_requests;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  greedy_word_wrap_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A width of zero behaves as a width of one.
  function automatic int unsigned usable_width();
    return (width_q == 8'd0) ? 1 : int'(width_q);
  endfunction

  // The buffer never holds more than the line can take, nor more than its depth.
  function automatic int unsigned piece_limit();
    return (usable_width() < WordMaxDef) ? usable_width() : WordMaxDef;
  endfunction

  function automatic void emit_char(logic [7:0] ch, logic done);
    out_word_t o;
    o.out_byte  = ch;
    o.run_last  = 1'b0;
    o.text_done = done;
    step_q.push_back(o);
  endfunction

  // Put the buffered word on the current line: straight on if the line is empty,
  // after one space if it still fits, otherwise after a line break. A line that
  // is already over the width (the width was lowered) always takes the break.
  function automatic void place_word();
    int unsigned len;
    len = word_len;
    if (len == 0) return;
    if (line_len == 0) begin
      line_len = len;
    end else if (line_len + 1 + len <= usable_width()) begin
      emit_char(ChSpace, 1'b0);
      line_len = line_len + 1 + len;
    end else begin
      emit_char(ChNewline, 1'b0);
      line_len = len;
    end
    for (int i = 0; i < len; i++) emit_char(word_buf[i], 1'b0);
    if (line_len > 255) line_len = 255;
    word_len = 0;
  endfunction

  // Works out every character that one accepted input byte releases.
  function automatic void wrap_char(in_word_t w);
    out_word_t o;
    if (w.in_byte == ChSpace) begin
      place_word();
    end else begin
      // A byte arriving at a full buffer pushes the buffered piece out first.
      if (word_len >= piece_limit()) place_word();
      if (word_len < WordMaxDef) begin
        word_buf[word_len] = w.in_byte;
        word_len++;
      end
    end
    if (w.text_end) begin
      place_word();
      emit_char(ChNewline, 1'b1);
      line_len = 0;
      word_len = 0;
    end
    if (step_q.size() != 0) begin
      o = step_q.pop_back();
      o.run_last = 1'b1;
      step_q.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void plan_row(row_kind_e k, logic [7:0] v, logic e, logic typed,
                                   logic one, out_word_t a);
    row_t r;
    r.kind       = k;
    r.value      = v;
    r.text_end   = e;
    r.typed      = typed;
    r.one_result = one;
    r.first      = a;
    plan_q.push_back(r);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ChSpace);
    return c;
  endfunction

  function automatic void add_text(logic [7:0] c, logic e);
    in_word_t w;
    w.in_byte  = c;
    w.text_end = e;
    text_q.push_back(w);
  endfunction

  // Appends one sentence of random words, or now and then a burst of raw noise.
  function automatic void build_sentence();
    int unsigned n_words;
    int unsigned len;
    int unsigned r;
    in_word_t    w;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6))
        add_text(($urandom_range(2) == 0) ? ChSpace : 8'($urandom_range(255)),
                 ($urandom_range(9) == 0));
      return;
    end
    n_words = $urandom_range(1, 8);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_text(ChSpace, 1'b0);
    for (int k = 0; k < n_words; k++) begin
      // Mostly short words; a few long enough to overflow the buffer.
      r = $urandom_range(99);
      if (r < 85) len = $urandom_range(1, 10);
      else if (r < 95) len = $urandom_range(11, 30);
      else len = $urandom_range(50, 70);
      repeat (len) add_text(text_byte(), 1'b0);
      if (k != n_words - 1) repeat ($urandom_range(1, 3)) add_text(ChSpace, 1'b0);
    end
    case ($urandom_range(3))
      0: begin
        w = text_q.pop_back();
        w.text_end = 1'b1;
        text_q.push_back(w);
      end
      1: add_text(ChSpace, 1'b1);
      2: begin
        add_text(ChSpace, 1'b0);
        add_text(ChSpace, 1'b1);
      end
      default: add_text(ChSpace, 1'b0);  // the text runs on into the next sentence
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with push still high, so
  // that a following word keeps the line up without a glitch.
  task automatic send_char(input in_word_t w, input logic typed, input logic one,
                           input out_word_t first);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    wrap_char(w);
    if (typed) begin
      step_q.delete();
      if (one) wrapped_q.push_back(first);
    end else begin
      while (step_q.size() != 0) wrapped_q.push_back(step_q.pop_front());
    end
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every owed character has been taken.
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk_i);
    while (wrapped_q.size() != 0) @(negedge clk_i);
  endtask

  // The width is only changed with the unit idle. A byte that produced nothing may
  // still be in flight after the last result, hence the settle pause.
  task automatic write_width(input logic [7:0] v);
    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    width_q = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < MaxPrinted)
      $display("%0t: %s: got 0x%02h, wanted 0x%02h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && pop && !empty) begin
      if (wrapped_q.size() == 0) begin
        report_mismatch("result with nothing owed", out_word.out_byte, 8'd0);
      end else begin
        want = wrapped_q.pop_front();
        if (out_word.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_word.out_byte, want.out_byte);
        if (out_word.run_last !== want.run_last)
          report_mismatch("run_last", 8'(out_word.run_last), 8'(want.run_last));
        if (out_word.text_done !== want.text_done)
          report_mismatch("text_done", 8'(out_word.text_done), 8'(want.text_done));
      end
    end
  end

  // Counts cycles in which no word moves on any port.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("greedy_word_wrap_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request so that the unit
  // fills up and stalls its input.
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned holds_seen;
    int unsigned hold_left;
    holds_seen = 0;
    hold_left  = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = RxHoldCycles;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    row_t       r;
    in_word_t   w;
    logic [7:0] phase_width;
    int         half;

    push          = 1'b0;
    in_word       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    rst_ni        = 1'b0;
    tx_idle_pct   = 8;
    rx_idle_pct   = 67;
    hold_requests = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    width_q       = LineWidthReset;
    word_len      = 0;
    line_len      = 0;
    foreach (word_buf[i]) word_buf[i] = 8'd0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, at the reset width first. A leading space and a run of
    // spaces yield nothing; a word ends on its space.
    plan_row(ROW_CHAR, ChSpace, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h41, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, ChSpace, 1'b0, 1'b1, 1'b1, {8'h41, 1'b1, 1'b0});
    plan_row(ROW_CHAR, ChSpace, 1'b0, 1'b1, 1'b0, NoWord);
    // Extreme byte values are ordinary word characters.
    plan_row(ROW_CHAR, 8'h00, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'hFF, 1'b1, 1'b0, 1'b0, NoWord);
    // Text end with no word pending on an empty line: one bare closing break.
    plan_row(ROW_CHAR, ChSpace, 1'b1, 1'b1, 1'b1, {ChNewline, 1'b1, 1'b1});
    // A line break byte inside a word is just another character.
    plan_row(ROW_CHAR, ChNewline, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h42, 1'b1, 1'b0, 1'b0, NoWord);
    // Zero width acts as one: every character is a piece of its own.
    plan_row(ROW_WIDTH, 8'd0, 1'b0, 1'b0, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h78, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h79, 1'b0, 1'b1, 1'b1, {8'h78, 1'b1, 1'b0});
    plan_row(ROW_CHAR, ChSpace, 1'b1, 1'b0, 1'b0, NoWord);
    // Width lowered while a word is buffered: the word overruns a fresh line
    // and the next word must start on a new one.
    plan_row(ROW_WIDTH, 8'd80, 1'b0, 1'b0, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h61, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h62, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h63, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h64, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_WIDTH, 8'd2, 1'b0, 1'b0, 1'b0, NoWord);
    plan_row(ROW_CHAR, ChSpace, 1'b0, 1'b0, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h65, 1'b1, 1'b0, 1'b0, NoWord);
    // Width changed part way along a line.
    plan_row(ROW_WIDTH, 8'd80, 1'b0, 1'b0, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h66, 1'b0, 1'b1, 1'b0, NoWord);
    plan_row(ROW_CHAR, ChSpace, 1'b0, 1'b1, 1'b1, {8'h66, 1'b1, 1'b0});
    plan_row(ROW_WIDTH, 8'd1, 1'b0, 1'b0, 1'b0, NoWord);
    plan_row(ROW_CHAR, 8'h67, 1'b1, 1'b0, 1'b0, NoWord);

    foreach (plan_q[i]) begin
      r = plan_q[i];
      if (r.kind == ROW_WIDTH) begin
        write_width(r.value);
      end else begin
        w.in_byte  = r.value;
        w.text_end = r.text_end;
        send_char(w, r.typed, r.one_result, r.first);
      end
    end

    // Random part. Each phase sets its own width on top of whatever line and word
    // the previous phase left behind, and its own idling pattern.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin phase_width = 8'd255; tx_idle_pct = 8;  rx_idle_pct = 67; end
        1: begin phase_width = 8'd1;   tx_idle_pct = 8;  rx_idle_pct = 67; end
        2: begin phase_width = 8'd57;  tx_idle_pct = 67; rx_idle_pct = 8;  end
        3: begin phase_width = 8'd12;  tx_idle_pct = 67; rx_idle_pct = 8;  end
        4: begin
          phase_width = 8'($urandom_range(2, 254));
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        default: begin phase_width = 8'd40; tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_width(phase_width);
      text_q.delete();
      while (text_q.size() < RandomPerPhase) build_sentence();
      // The last sentence is cut short; its text simply runs on into the next phase.
      while (text_q.size() > RandomPerPhase) void'(text_q.pop_back());
      // The receiver stops taking results for a long stretch while text keeps coming.
      if (p == 4) hold_requests++;
      half = text_q.size() / 2;
      foreach (text_q[i]) begin
        // Halfway through one phase the sender waits for the unit to empty.
        if (p == 2 && i == half) drain_results();
        send_char(text_q[i], 1'b0, 1'b0, NoWord);
      end
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("greedy_word_wrap_unit verification clean");
    end else begin
      $display("greedy_word_wrap_unit verification failed");
    end
    $finish;
  end

endmodule
